### sv/hmfei_pkg.sv
// ----------------------------------------------------------------------------
// hmfei_pkg: shared types and constants of the Markov frame error injector
// Action and register codes, frame classification constants, microcode
// control word and the sequencer program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hmfei_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_TRANS,
    ACT_LOAD_ERR,
    ACT_FRAME,
    ACT_TIMER
  } action_t;

  typedef enum logic [1:0] {
    CFG_TIME_MODE,
    CFG_STATE_COUNT,
    CFG_INIT_STATE,
    CFG_SEED
  } cfg_reg_t;

  localparam logic [15:0] ETHER_IPV4      = 16'h0800;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [11:0] TCP_MIN_PAYLOAD = 12'd4;
  localparam logic [31:0] LFSR_MASK       = 32'h8020_0003;

  localparam logic       RST_TIME_MODE   = 1'b1;
  localparam logic [4:0] RST_STATE_COUNT = 5'd16;

  // microcode program addresses
  typedef logic [3:0] step_t;
  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_DISP   = 4'd1;
  localparam step_t ST_CLASS  = 4'd2;
  localparam step_t ST_DECIDE = 4'd3;
  localparam step_t ST_CHK    = 4'd4;
  localparam step_t ST_COL    = 4'd5;
  localparam step_t ST_DRN1   = 4'd6;
  localparam step_t ST_DRN2   = 4'd7;
  localparam step_t ST_COMMIT = 4'd8;
  localparam step_t ST_EMIT   = 4'd9;
  localparam step_t ST_LOAD   = 4'd10;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_LOAD,
    JMP_NO_DRAW,
    JMP_NO_MOVE,
    JMP_COL_MORE
  } cond_t;

  typedef struct packed {
    wait_t wait_on;
    cond_t cond;
    step_t target;
    logic  accept;
    logic  decide;
    logic  col_issue;
    logic  commit;
    logic  load;
    logic  emit;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic is_load;
    logic no_draw;
    logic no_move;
    logic col_more;
  } stat_t;

  // control ROM: one word per program step
  function automatic ctl_t ucode(step_t s);
    ctl_t c;
    c = '0;
    unique case (s)
      ST_IDLE: begin
        c.accept  = 1'b1;
        c.wait_on = WAIT_IN;
      end
      ST_DISP: begin
        c.cond   = JMP_LOAD;
        c.target = ST_LOAD;
      end
      ST_CLASS: begin
        c.cond   = JMP_NO_DRAW;
        c.target = ST_CHK;
      end
      ST_DECIDE: begin
        c.decide = 1'b1;
      end
      ST_CHK: begin
        c.cond   = JMP_NO_MOVE;
        c.target = ST_EMIT;
      end
      ST_COL: begin
        c.col_issue = 1'b1;
        c.cond      = JMP_COL_MORE;
        c.target    = ST_COL;
      end
      ST_DRN1, ST_DRN2: begin
        c.cond = JMP_NONE;
      end
      ST_COMMIT: begin
        c.commit = 1'b1;
      end
      ST_EMIT: begin
        c.emit    = 1'b1;
        c.wait_on = WAIT_OUT;
        c.cond    = JMP_ALWAYS;
        c.target  = ST_IDLE;
      end
      ST_LOAD: begin
        c.load   = 1'b1;
        c.cond   = JMP_ALWAYS;
        c.target = ST_EMIT;
      end
      default: begin
        c.cond   = JMP_ALWAYS;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

### sv/hmfei_in_if.sv
// ----------------------------------------------------------------------------
// hmfei_in_if: input item channel
// Valid/ready handshake with load, frame and timer item fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hmfei_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  row_index;
  logic [3:0]  column_index;
  logic [15:0] prob_value;
  logic        is_data_frame;
  logic        is_broadcast;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [11:0] tcp_payload_bytes;

  modport source (
    output valid, action, row_index, column_index, prob_value, is_data_frame,
           is_broadcast, ether_type, ip_protocol, tcp_payload_bytes,
    input  ready
  );

  modport sink (
    input  valid, action, row_index, column_index, prob_value, is_data_frame,
           is_broadcast, ether_type, ip_protocol, tcp_payload_bytes,
    output ready
  );
endinterface

### sv/hmfei_out_if.sv
// ----------------------------------------------------------------------------
// hmfei_out_if: result item channel
// Valid/ready handshake carrying the corruption flag and hidden state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hmfei_out_if;
  logic       valid;
  logic       ready;
  logic       corrupted;
  logic [3:0] current_state_out;
  logic       state_changed;

  modport source (
    output valid, corrupted, current_state_out, state_changed,
    input  ready
  );

  modport sink (
    input  valid, corrupted, current_state_out, state_changed,
    output ready
  );
endinterface

### sv/hmfei_ram.sv
// ----------------------------------------------------------------------------
// hmfei_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmfei_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/hmfei_lfsr.sv
// ----------------------------------------------------------------------------
// hmfei_lfsr: uniform random source
// 32-bit Galois LFSR shifting right; a draw is the top bits after one step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmfei_lfsr #(
  parameter int PROB_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic [31:0]          seed,
  input  logic                 advance,
  output logic [PROB_BITS-1:0] draw
);

  logic [31:0] lfsr_r;
  logic [31:0] lfsr_nxt;

  always_comb begin
    lfsr_nxt = {1'b0, lfsr_r[31:1]};
    if (lfsr_r[0]) begin
      lfsr_nxt = lfsr_nxt ^ hmfei_pkg::LFSR_MASK;
    end
  end

  assign draw = lfsr_nxt[31 -: PROB_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= 32'd1;
    end else if (load) begin
      // an all-zero seed would lock up the register
      lfsr_r <= (seed == 32'd0) ? 32'd1 : seed;
    end else if (advance) begin
      lfsr_r <= lfsr_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != 32'd0)
    else $error("LFSR reached the all-zero lock-up state");
`endif

endmodule

### sv/hmfei_seq.sv
// ----------------------------------------------------------------------------
// hmfei_seq: microcode sequencer
// Step counter over the control ROM with stalls and conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmfei_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  hmfei_pkg::stat_t  stat,
  output hmfei_pkg::ctl_t   ctl
);

  hmfei_pkg::step_t step_r;
  hmfei_pkg::step_t step_nxt;
  logic             hold;
  logic             take;

  assign ctl = hmfei_pkg::ucode(step_r);

  always_comb begin
    unique case (ctl.wait_on)
      hmfei_pkg::WAIT_IN:  hold = !stat.in_valid;
      hmfei_pkg::WAIT_OUT: hold = stat.out_busy;
      default:             hold = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctl.cond)
      hmfei_pkg::JMP_ALWAYS:   take = 1'b1;
      hmfei_pkg::JMP_LOAD:     take = stat.is_load;
      hmfei_pkg::JMP_NO_DRAW:  take = stat.no_draw;
      hmfei_pkg::JMP_NO_MOVE:  take = stat.no_move;
      hmfei_pkg::JMP_COL_MORE: take = stat.col_more;
      default:                 take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (hold) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = ctl.target;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= hmfei_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### sv/hidden_markov_frame_error_injector.sv
// ----------------------------------------------------------------------------
// hidden_markov_frame_error_injector: Markov channel frame error injector
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    action, indexes, probability, frame header
//   out_ch   out  valid/ready    corrupted, current_state_out, state_changed
//   cfg_*    in   write enable   time_mode, state_count, initial_state, seed
//
// A load item runs the idle, dispatch, load and emit steps; a frame or timer
// item without a state change skips the column walk, and an item that walks
// the transition row covers the states in use: the column walk issues
// one transition read and one LFSR draw per cycle, followed by a two-stage
// multiply and compare. Synchronous active-low reset; no clearing pass.
// A result held in the output register stalls the sequencer only at its
// emit step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hidden_markov_frame_error_injector #(
  parameter int MAX_STATES = 16,
  parameter int PROB_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hmfei_in_if.sink    in_ch,
  hmfei_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int SW  = $clog2(MAX_STATES);
  localparam int TAW = $clog2(MAX_STATES * MAX_STATES);
  localparam int IW  = SW + 4;
  localparam int CW  = SW + 6;
  localparam int PW  = 2 * PROB_BITS;
  localparam logic [TAW-1:0] MaxT = TAW'(MAX_STATES);

  hmfei_pkg::ctl_t  ctl;
  hmfei_pkg::stat_t stat;

  // configuration and hidden state
  logic          time_mode_r;
  logic [4:0]    state_count_r;
  logic [SW-1:0] hidden_r;

  // latched item
  hmfei_pkg::action_t act_r;
  logic [3:0]         row_r;
  logic [3:0]         col_in_r;
  logic [15:0]        prob_r;
  logic               data_r;
  logic               bcast_r;
  logic [15:0]        ether_r;
  logic [7:0]         proto_r;
  logic [11:0]        payload_r;

  // column walk
  logic [SW-1:0] col_r;
  logic          valid_a_r;
  logic [SW-1:0] col_a_r;
  logic          valid_b_r;
  logic [SW-1:0] col_b_r;
  logic [PW-1:0] prod_r;
  logic          have_r;
  logic [PW-1:0] best_val_r;
  logic [SW-1:0] best_r;

  logic corrupted_r;
  logic changed_r;

  logic       out_valid_r;
  logic       out_corrupted_r;
  logic [3:0] out_state_r;
  logic       out_changed_r;

  logic                 accept;
  logic                 emit_fire;
  logic [PROB_BITS-1:0] draw;
  logic [PROB_BITS-1:0] err_rd;
  logic [PROB_BITS-1:0] tr_rd;
  logic [PROB_BITS-1:0] prob_q;
  logic [PROB_BITS+15:0] prob_w;
  logic [IW-1:0]        row_w;
  logic [IW-1:0]        col_w;
  logic [IW-1:0]        init_w;
  logic [IW-1:0]        hs_w;
  logic                 row_ok;
  logic                 col_ok;
  logic [CW-1:0]        sc_w;
  logic [CW-1:0]        last_w;
  logic [SW-1:0]        last_col;
  logic                 eligible;
  logic                 must_leave;
  logic                 tr_we;
  logic                 err_we;
  logic [TAW-1:0]       tr_waddr;
  logic [TAW-1:0]       tr_raddr;
  logic                 take_col;

  hmfei_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  hmfei_lfsr #(.PROB_BITS(PROB_BITS)) u_lfsr (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (cfg_we && (hmfei_pkg::cfg_reg_t'(cfg_index) == hmfei_pkg::CFG_SEED)),
    .seed    (cfg_wdata),
    .advance (ctl.decide || valid_a_r),
    .draw    (draw)
  );

  hmfei_ram #(.WIDTH(PROB_BITS), .DEPTH(MAX_STATES * MAX_STATES)) u_tr_ram (
    .clk   (clk),
    .we    (tr_we),
    .waddr (tr_waddr),
    .wdata (prob_q),
    .raddr (tr_raddr),
    .rdata (tr_rd)
  );

  hmfei_ram #(.WIDTH(PROB_BITS), .DEPTH(MAX_STATES)) u_err_ram (
    .clk   (clk),
    .we    (err_we),
    .waddr (row_w[SW-1:0]),
    .wdata (prob_q),
    .raddr (hidden_r),
    .rdata (err_rd)
  );

  // hold off input items while in reset
  assign accept    = in_ch.valid && ctl.accept && rst_n;
  assign emit_fire = ctl.emit && !stat.out_busy;

  // Q0.16 to Q0.PROB_BITS: scale up by 2^PROB_BITS, then drop 16 bits
  assign prob_w = {prob_r, PROB_BITS'(0)};
  assign prob_q = prob_w[PROB_BITS+15:16];

  assign row_w  = IW'(row_r);
  assign col_w  = IW'(col_in_r);
  assign init_w = IW'(cfg_wdata[3:0]);
  assign hs_w   = IW'(hidden_r);
  assign row_ok = row_w < IW'(MAX_STATES);
  assign col_ok = col_w < IW'(MAX_STATES);

  assign tr_we    = ctl.load && (act_r == hmfei_pkg::ACT_LOAD_TRANS) && row_ok && col_ok;
  assign err_we   = ctl.load && (act_r == hmfei_pkg::ACT_LOAD_ERR) && row_ok;
  assign tr_waddr = TAW'(row_w[SW-1:0]) * MaxT + TAW'(col_w[SW-1:0]);
  assign tr_raddr = TAW'(hidden_r) * MaxT + TAW'(col_r);

  // clamp the state count into two .. MAX_STATES, keep the last column
  assign sc_w = CW'(state_count_r);
  always_comb begin
    priority if (sc_w < CW'(2)) begin
      last_w = CW'(1);
    end else if (sc_w > CW'(MAX_STATES)) begin
      last_w = CW'(MAX_STATES - 1);
    end else begin
      last_w = sc_w - CW'(1);
    end
  end
  assign last_col = last_w[SW-1:0];

  assign eligible = data_r && !bcast_r && (ether_r == hmfei_pkg::ETHER_IPV4) &&
                    ((proto_r == hmfei_pkg::PROTO_UDP) ||
                     ((proto_r == hmfei_pkg::PROTO_TCP) &&
                      (payload_r > hmfei_pkg::TCP_MIN_PAYLOAD)));

  assign must_leave = (act_r == hmfei_pkg::ACT_TIMER);
  assign take_col   = valid_b_r && !(must_leave && (col_b_r == hidden_r)) &&
                      (!have_r || (prod_r > best_val_r));

  always_comb begin
    stat.in_valid = in_ch.valid;
    stat.out_busy = out_valid_r && !out_ch.ready;
    stat.is_load  = (act_r == hmfei_pkg::ACT_LOAD_TRANS) ||
                    (act_r == hmfei_pkg::ACT_LOAD_ERR);
    stat.no_draw  = (act_r != hmfei_pkg::ACT_FRAME) || !eligible;
    stat.no_move  = ((act_r == hmfei_pkg::ACT_FRAME) && time_mode_r) ||
                    ((act_r == hmfei_pkg::ACT_TIMER) && !time_mode_r);
    stat.col_more = (col_r != last_col);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_mode_r   <= hmfei_pkg::RST_TIME_MODE;
      state_count_r <= hmfei_pkg::RST_STATE_COUNT;
      hidden_r      <= '0;
      valid_a_r     <= 1'b0;
      valid_b_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (hmfei_pkg::cfg_reg_t'(cfg_index))
          hmfei_pkg::CFG_TIME_MODE:   time_mode_r   <= cfg_wdata[0];
          hmfei_pkg::CFG_STATE_COUNT: state_count_r <= cfg_wdata[4:0];
          hmfei_pkg::CFG_INIT_STATE:
            hidden_r <= (init_w < IW'(MAX_STATES)) ? init_w[SW-1:0] : '0;
          hmfei_pkg::CFG_SEED:        state_count_r <= state_count_r;
        endcase
      end else if (ctl.commit) begin
        hidden_r <= best_r;
      end
      valid_a_r <= ctl.col_issue;
      valid_b_r <= valid_a_r;
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r       <= hmfei_pkg::action_t'(in_ch.action);
      row_r       <= in_ch.row_index;
      col_in_r    <= in_ch.column_index;
      prob_r      <= in_ch.prob_value;
      data_r      <= in_ch.is_data_frame;
      bcast_r     <= in_ch.is_broadcast;
      ether_r     <= in_ch.ether_type;
      proto_r     <= in_ch.ip_protocol;
      payload_r   <= in_ch.tcp_payload_bytes;
      corrupted_r <= 1'b0;
      changed_r   <= 1'b0;
      col_r       <= '0;
      have_r      <= 1'b0;
      best_r      <= hidden_r;
    end else begin
      if (ctl.decide) begin
        corrupted_r <= (draw < err_rd);
      end
      if (ctl.col_issue) begin
        col_r <= col_r + SW'(1);
      end
      if (take_col) begin
        have_r     <= 1'b1;
        best_val_r <= prod_r;
        best_r     <= col_b_r;
      end
      if (ctl.commit) begin
        changed_r <= (best_r != hidden_r);
      end
    end
    // stage A issued the read last cycle: multiply with this cycle's draw
    col_a_r <= col_r;
    col_b_r <= col_a_r;
    prod_r  <= PW'(tr_rd) * PW'(draw);
    if (emit_fire) begin
      out_corrupted_r <= corrupted_r;
      out_state_r     <= hs_w[3:0];
      out_changed_r   <= changed_r;
    end
  end

  assign in_ch.ready              = ctl.accept && rst_n;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.corrupted         = out_corrupted_r;
  assign out_ch.current_state_out = out_state_r;
  assign out_ch.state_changed     = out_changed_r;

`ifndef ASSERT_OFF
  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> (changed_r == (hidden_r != $past(hidden_r))))
    else $error("state_changed flag disagrees with the committed state");

  a_timer_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && (act_r == hmfei_pkg::ACT_TIMER)) |=> (hidden_r != $past(hidden_r)))
    else $error("timer transition stayed in the current state");

  a_timer_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && (act_r == hmfei_pkg::ACT_TIMER)) |=> !out_ch.corrupted)
    else $error("timer item reported as corrupted");
`endif

endmodule
